[src/csrsm_pkg.sv]
// Shared types and constants for the CSR sparse matrix engine.
// No dependencies; used by csr_sparse_matrix_engine_core.
`timescale 1ns / 1ps
package csrsm_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int MAX_ENTRIES = 256;

    // item kinds
    localparam logic [2:0] KIND_LOAD_PTR   = 3'd0;
    localparam logic [2:0] KIND_LOAD_ENTRY = 3'd1;
    localparam logic [2:0] KIND_READ       = 3'd2;
    localparam logic [2:0] KIND_WRITE      = 3'd3;
    localparam logic [2:0] KIND_LOAD_VEC   = 3'd4;
    localparam logic [2:0] KIND_MULTIPLY   = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // config register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RP,
        ST_RADDR,
        ST_RCHK,
        ST_WADDR,
        ST_WCHK,
        ST_INS,
        ST_SHR,
        ST_SHW,
        ST_PUT,
        ST_PINC,
        ST_MSTART,
        ST_MADDR,
        ST_MCOL,
        ST_MVEC,
        ST_MACC,
        ST_MEMIT
    } state_t;

endpackage

[src/csr_sparse_matrix_engine_core.sv]
// CSR sparse matrix engine: top level, sequencer and storage.
// Depends on csrsm_pkg.
`timescale 1ns / 1ps
// Usage:
//  - Input words arrive on s_tvalid/s_tready/s_tdata with the item kind on
//    s_tuser. A word is taken when s_tvalid and s_tready are both high.
//  - Results leave on m_tvalid/m_tready/m_tdata; status rides on m_tuser and
//    m_tlast marks the final result of an item.
//  - The user writes num_rows / num_cols via cfg_we/cfg_index/cfg_wdata while
//    the block is idle, which it does not enforce; values are clamped to 1..64.
//  - Loads and out-of-range items answer in the cycle after acceptance.
//  - Read: fetches the row pointers, then checks each stored entry of the row.
//  - Write: walks the row like a read; an insert shifts the entries from the slot
//    up to entry_count one place up, then increments each following row pointer.
//  - Multiply: per row, each stored entry is read, its vector element read,
//    multiplied and summed (an entry whose column is out of use is skipped);
//    the single entry memory read port and one 32x32 multiplier pace this.
//  - One item is worked at a time; s_tready is low while an item is busy or
//    a result waits. A stalled receiver simply holds the sequencer.
//  - Reset clears row pointers and entry count and sets num_rows / num_cols to
//    64; entry and vector memories hold nothing defined until loaded.
module csr_sparse_matrix_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // row[6:0], col[13:7], position[22:14], data_value[54:23]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // result_value[63:0], result_row[69:64]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata
);

    csrsm_pkg::state_t state_reg, state_next;

    logic [6:0]  num_rows_reg, num_cols_reg;
    logic [8:0]  ec_reg, ec_next;

    // row pointers: memory with two registered reads, valid bits for reset
    logic [8:0]  rp_mem [0:64];
    logic [64:0] rp_vld_reg;
    logic [8:0]  rp_rd0, rp_rd1;
    logic [6:0]  rp_ra0, rp_ra1;

    logic [5:0]  col_mem [0:255];
    logic [31:0] val_mem [0:255];
    logic [31:0] vec_mem [0:63];
    logic [5:0]  col_rd;
    logic [31:0] val_rd, vec_rd;

    // latched item
    logic [2:0]  kind_reg, kind_next;
    logic [6:0]  row_reg, row_next;
    logic [6:0]  col_reg, col_next;
    logic [31:0] data_reg, data_next;

    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  end_reg, end_next;
    logic [8:0]  p_reg, p_next;
    logic [6:0]  i_reg, i_next;
    logic signed [63:0] sum_reg, sum_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] mval_reg, mval_next;

    logic        ov_reg, ov_next;
    logic [63:0] ovalue_reg, ovalue_next;
    logic [5:0]  orow_reg, orow_next;
    logic [1:0]  ostat_reg, ostat_next;
    logic        olast_reg, olast_next;

    // memory port controls
    logic        e_we;
    logic [7:0]  e_waddr, e_raddr;
    logic [5:0]  e_wcol;
    logic [31:0] e_wval;
    logic        v_we;
    logic [5:0]  v_waddr, v_raddr;
    logic        rp_we;
    logic [6:0]  rp_waddr;
    logic [8:0]  rp_wdata;

    logic        accept;
    logic        out_take;
    logic [6:0]  in_row, in_col;
    logic [8:0]  in_pos;
    logic [31:0] in_data;
    logic [5:0]  colm1;
    logic [8:0]  rp_end;
    logic [6:0]  cfg_max;
    logic [6:0]  cfg_sat;

    assign in_row  = s_tdata[6:0];
    assign in_col  = s_tdata[13:7];
    assign in_pos  = s_tdata[22:14];
    assign in_data = s_tdata[54:23];
    assign colm1   = 6'(col_reg - 7'd1);

    assign s_tready = (state_reg == csrsm_pkg::ST_IDLE) && !ov_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = ov_reg && m_tready;

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, orow_reg, ovalue_reg};
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

    always_comb
    begin
        if (cfg_index == csrsm_pkg::REG_NUM_ROWS)
            cfg_max = 7'(csrsm_pkg::MAX_ROWS);
        else
            cfg_max = 7'(csrsm_pkg::MAX_COLS);
        if (cfg_wdata == 7'd0)
            cfg_sat = 7'd1;
        else if (cfg_wdata > cfg_max)
            cfg_sat = cfg_max;
        else
            cfg_sat = cfg_wdata;
    end

    // end pointer of current row, clamped
    always_comb
    begin
        if (rp_rd1 > 9'(csrsm_pkg::MAX_ENTRIES))
            rp_end = 9'(csrsm_pkg::MAX_ENTRIES);
        else
            rp_end = rp_rd1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csrsm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == csrsm_pkg::KIND_READ || s_tuser == csrsm_pkg::KIND_WRITE)
                    begin
                        if (!(in_row < 7'd1 || in_row > num_rows_reg ||
                              in_col < 7'd1 || in_col > num_cols_reg))
                            state_next = csrsm_pkg::ST_RP;
                    end
                    else if (s_tuser == csrsm_pkg::KIND_MULTIPLY)
                        state_next = csrsm_pkg::ST_MSTART;
                end
            end
            csrsm_pkg::ST_RP:
            begin
                if (kind_reg == csrsm_pkg::KIND_WRITE)
                    state_next = csrsm_pkg::ST_WADDR;
                else if (ec_reg == 9'd0)
                    state_next = csrsm_pkg::ST_IDLE;
                else
                    state_next = csrsm_pkg::ST_RADDR;
            end
            csrsm_pkg::ST_RADDR:
                state_next = (pos_reg >= end_reg) ? csrsm_pkg::ST_IDLE : csrsm_pkg::ST_RCHK;
            csrsm_pkg::ST_RCHK:
                state_next = (col_rd == colm1) ? csrsm_pkg::ST_IDLE : csrsm_pkg::ST_RADDR;
            csrsm_pkg::ST_WADDR:
                state_next = (pos_reg >= end_reg) ? csrsm_pkg::ST_INS : csrsm_pkg::ST_WCHK;
            csrsm_pkg::ST_WCHK:
            begin
                if (colm1 < col_rd)
                    state_next = csrsm_pkg::ST_INS;
                else if (col_rd == colm1)
                    state_next = csrsm_pkg::ST_IDLE;
                else
                    state_next = csrsm_pkg::ST_WADDR;
            end
            csrsm_pkg::ST_INS:
                state_next = (ec_reg >= 9'(csrsm_pkg::MAX_ENTRIES)) ?
                             csrsm_pkg::ST_IDLE : csrsm_pkg::ST_SHR;
            csrsm_pkg::ST_SHR:
                state_next = (p_reg > pos_reg) ? csrsm_pkg::ST_SHW : csrsm_pkg::ST_PUT;
            csrsm_pkg::ST_SHW:
                state_next = csrsm_pkg::ST_SHR;
            csrsm_pkg::ST_PUT:
                state_next = csrsm_pkg::ST_PINC;
            csrsm_pkg::ST_PINC:
                state_next = (i_reg <= num_rows_reg) ? csrsm_pkg::ST_PINC : csrsm_pkg::ST_IDLE;
            csrsm_pkg::ST_MSTART:
                state_next = csrsm_pkg::ST_MADDR;
            csrsm_pkg::ST_MADDR:
                state_next = (pos_reg >= end_reg) ? csrsm_pkg::ST_MEMIT : csrsm_pkg::ST_MCOL;
            csrsm_pkg::ST_MCOL:
                state_next = ({1'b0, col_rd} < num_cols_reg) ?
                             csrsm_pkg::ST_MVEC : csrsm_pkg::ST_MADDR;
            csrsm_pkg::ST_MVEC:
                state_next = csrsm_pkg::ST_MACC;
            csrsm_pkg::ST_MACC:
                state_next = csrsm_pkg::ST_MADDR;
            csrsm_pkg::ST_MEMIT:
            begin
                if (out_take)
                    state_next = olast_reg ? csrsm_pkg::ST_IDLE : csrsm_pkg::ST_MSTART;
            end
            default:
                state_next = csrsm_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next   = kind_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        data_next   = data_reg;
        pos_next    = pos_reg;
        end_next    = end_reg;
        p_next      = p_reg;
        i_next      = i_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        mval_next   = mval_reg;
        ec_next     = ec_reg;
        ov_next     = out_take ? 1'b0 : ov_reg;
        ovalue_next = ovalue_reg;
        orow_next   = orow_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;
        e_we        = 1'b0;
        e_waddr     = p_reg[7:0];
        e_raddr     = pos_reg[7:0];
        e_wcol      = col_rd;
        e_wval      = val_rd;
        v_we        = 1'b0;
        v_waddr     = in_col[5:0];
        v_raddr     = col_rd;
        rp_we       = 1'b0;
        rp_waddr    = i_reg;
        rp_wdata    = rp_rd0 + 9'd1;
        // next row's pointers: pointer walk and multiply row start
        rp_ra0      = i_reg + 7'd1;
        rp_ra1      = i_reg + 7'd2;

        case (state_reg)
            csrsm_pkg::ST_IDLE:
            begin
                // fetch the pointers the item will need in the cycle after acceptance
                if (s_tuser == csrsm_pkg::KIND_MULTIPLY)
                begin
                    rp_ra0 = 7'd0;
                    rp_ra1 = 7'd1;
                end
                else
                begin
                    rp_ra0 = in_row - 7'd1;
                    rp_ra1 = in_row;
                end
                if (accept)
                begin
                    kind_next   = s_tuser;
                    row_next    = in_row;
                    col_next    = in_col;
                    data_next   = in_data;
                    i_next      = 7'd0;
                    ovalue_next = 64'd0;
                    orow_next   = 6'd0;
                    olast_next  = 1'b1;
                    ostat_next  = csrsm_pkg::STAT_OK;
                    ov_next     = 1'b1;
                    case (s_tuser)
                        csrsm_pkg::KIND_LOAD_PTR:
                        begin
                            if (in_row > num_rows_reg || in_pos > 9'(csrsm_pkg::MAX_ENTRIES))
                                ostat_next = csrsm_pkg::STAT_RANGE;
                            else
                            begin
                                rp_we    = 1'b1;
                                rp_waddr = in_row;
                                rp_wdata = in_pos;
                            end
                        end
                        csrsm_pkg::KIND_LOAD_ENTRY:
                        begin
                            if (in_pos >= 9'(csrsm_pkg::MAX_ENTRIES) || in_col >= num_cols_reg)
                                ostat_next = csrsm_pkg::STAT_RANGE;
                            else
                            begin
                                e_we    = 1'b1;
                                e_waddr = in_pos[7:0];
                                e_wcol  = in_col[5:0];
                                e_wval  = in_data;
                                if (ec_reg < in_pos + 9'd1)
                                    ec_next = in_pos + 9'd1;
                            end
                        end
                        csrsm_pkg::KIND_LOAD_VEC:
                        begin
                            if (in_col >= num_cols_reg)
                                ostat_next = csrsm_pkg::STAT_RANGE;
                            else
                                v_we = 1'b1;
                        end
                        csrsm_pkg::KIND_READ, csrsm_pkg::KIND_WRITE:
                        begin
                            if (in_row < 7'd1 || in_row > num_rows_reg ||
                                in_col < 7'd1 || in_col > num_cols_reg)
                                ostat_next = csrsm_pkg::STAT_RANGE;
                            else
                                ov_next = 1'b0;
                        end
                        csrsm_pkg::KIND_MULTIPLY:
                            ov_next = 1'b0;
                        default:
                            ostat_next = csrsm_pkg::STAT_RANGE;
                    endcase
                end
            end
            csrsm_pkg::ST_RP:
            begin
                pos_next = rp_rd0;
                end_next = rp_end;
                if (kind_reg == csrsm_pkg::KIND_READ && ec_reg == 9'd0)
                    ov_next = 1'b1;   // empty store reads zero
            end
            csrsm_pkg::ST_RADDR:
            begin
                if (pos_reg >= end_reg)
                    ov_next = 1'b1;
            end
            csrsm_pkg::ST_RCHK:
            begin
                if (col_rd == colm1)
                begin
                    ovalue_next = {{32{val_rd[31]}}, val_rd};
                    ov_next     = 1'b1;
                end
                else
                    pos_next = pos_reg + 9'd1;
            end
            csrsm_pkg::ST_WCHK:
            begin
                if (!(colm1 < col_rd))
                begin
                    if (col_rd == colm1)
                    begin
                        e_we        = 1'b1;
                        e_waddr     = pos_reg[7:0];
                        e_wcol      = col_rd;
                        e_wval      = data_reg;
                        ovalue_next = {{32{data_reg[31]}}, data_reg};
                        ov_next     = 1'b1;
                    end
                    else
                        pos_next = pos_reg + 9'd1;
                end
            end
            csrsm_pkg::ST_INS:
            begin
                if (ec_reg >= 9'(csrsm_pkg::MAX_ENTRIES))
                begin
                    ostat_next = csrsm_pkg::STAT_FULL;
                    ov_next    = 1'b1;
                end
                else
                begin
                    if (pos_reg > ec_reg)
                        pos_next = ec_reg;
                    p_next = ec_reg;
                end
            end
            csrsm_pkg::ST_SHR:
                e_raddr = 8'(p_reg - 9'd1);
            csrsm_pkg::ST_SHW:
            begin
                e_we    = 1'b1;
                e_waddr = p_reg[7:0];
                p_next  = p_reg - 9'd1;
            end
            csrsm_pkg::ST_PUT:
            begin
                e_we    = 1'b1;
                e_waddr = pos_reg[7:0];
                e_wcol  = colm1;
                e_wval  = data_reg;
                i_next  = row_reg;
                rp_ra0  = row_reg;
            end
            csrsm_pkg::ST_PINC:
            begin
                // rp_rd0 holds pointer i; pointer i+1 is fetched meanwhile
                if (i_reg <= num_rows_reg)
                begin
                    rp_we  = (rp_rd0 < 9'(csrsm_pkg::MAX_ENTRIES));
                    i_next = i_reg + 7'd1;
                end
                else
                begin
                    ec_next     = ec_reg + 9'd1;
                    ovalue_next = {{32{data_reg[31]}}, data_reg};
                    ov_next     = 1'b1;
                end
            end
            csrsm_pkg::ST_MSTART:
            begin
                pos_next = rp_rd0;
                end_next = rp_end;
                sum_next = 64'sd0;
            end
            csrsm_pkg::ST_MADDR:
            begin
                if (pos_reg >= end_reg)
                begin
                    ovalue_next = sum_reg;
                    orow_next   = i_reg[5:0];
                    ostat_next  = csrsm_pkg::STAT_OK;
                    olast_next  = (i_reg + 7'd1 == num_rows_reg);
                    ov_next     = 1'b1;
                end
            end
            csrsm_pkg::ST_MCOL:
            begin
                mval_next = val_rd;
                if (!({1'b0, col_rd} < num_cols_reg))
                    pos_next = pos_reg + 9'd1;
            end
            csrsm_pkg::ST_MVEC:
                prod_next = mval_reg * $signed(vec_rd);
            csrsm_pkg::ST_MACC:
            begin
                sum_next = sum_reg + prod_reg;
                pos_next = pos_reg + 9'd1;
            end
            csrsm_pkg::ST_MEMIT:
            begin
                if (out_take && !olast_reg)
                    i_next = i_reg + 7'd1;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= csrsm_pkg::ST_IDLE;
            num_rows_reg <= 7'(csrsm_pkg::MAX_ROWS);
            num_cols_reg <= 7'(csrsm_pkg::MAX_COLS);
            ec_reg       <= 9'd0;
            ov_reg       <= 1'b0;
            rp_vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ec_reg    <= ec_next;
            ov_reg    <= ov_next;
            if (rp_we)
                rp_vld_reg[rp_waddr] <= 1'b1;
            if (cfg_we)
            begin
                if (cfg_index == csrsm_pkg::REG_NUM_ROWS)
                    num_rows_reg <= cfg_sat;
                else
                    num_cols_reg <= cfg_sat;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        data_reg   <= data_next;
        pos_reg    <= pos_next;
        end_reg    <= end_next;
        p_reg      <= p_next;
        i_reg      <= i_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        mval_reg   <= mval_next;
        ovalue_reg <= ovalue_next;
        orow_reg   <= orow_next;
        ostat_reg  <= ostat_next;
        olast_reg  <= olast_next;
    end

    // row pointer memory: one write, two registered reads; a pointer never
    // written since reset reads as zero
    always_ff @(posedge clk)
    begin
        if (rp_we)
            rp_mem[rp_waddr] <= rp_wdata;
        rp_rd0 <= rp_vld_reg[rp_ra0] ? rp_mem[rp_ra0] : 9'd0;
        rp_rd1 <= rp_vld_reg[rp_ra1] ? rp_mem[rp_ra1] : 9'd0;
    end

    // entry memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            col_mem[e_waddr] <= e_wcol;
            val_mem[e_waddr] <= e_wval;
        end
        col_rd <= col_mem[e_raddr];
        val_rd <= val_mem[e_raddr];
    end

    // vector memory
    always_ff @(posedge clk)
    begin
        if (v_we)
            vec_mem[v_waddr] <= in_data;
        vec_rd <= vec_mem[v_raddr];
    end

endmodule
